### hdl/matrix_inverse_3x3_core_defines.svh
// Assertion macros shared by the RTL that carries checks.
`ifndef MATRIX_INVERSE_3X3_CORE_DEFINES_SVH
`define MATRIX_INVERSE_3X3_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define MI3_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define MI3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define MI3_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MI3_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hdl/mi3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mi3_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;
    localparam int MAT_N         = 9;

    // Cofactor operands a*b - c*d, in row-major order of the inverse.
    localparam int unsigned ADJ_IDX [MAT_N][4] = '{
        '{4, 8, 5, 7},
        '{2, 7, 1, 8},
        '{1, 5, 2, 4},
        '{5, 6, 3, 8},
        '{0, 8, 2, 6},
        '{2, 3, 0, 5},
        '{3, 7, 4, 6},
        '{1, 6, 0, 7},
        '{0, 4, 1, 3}
    };

endpackage

`default_nettype wire

### hdl/matrix_inverse_3x3_core.sv
`timescale 1ns / 1ps
`default_nettype none

// 3x3 fixed-point matrix inverse by adjugate over determinant. One matrix beat
// (nine signed WORD_BITS words with FRAC_BITS fraction bits) is taken per clock
// and one result beat leaves per clock; the words are Q16.16 at the defaults.
// The restoring divide retires one quotient bit per pipeline stage for all
// nine entries at once. The determinant is kept exact; each entry is
// adj * 2^(2*FRAC_BITS) / det truncated toward zero and clipped to the word
// range, with o_saturated high when any entry clipped. A zero determinant
// gives o_invertible low and all-zero entries. The whole pipeline holds while
// the output register has a beat and i_out_stall is high.

`include "matrix_inverse_3x3_core_defines.svh"

module matrix_inverse_3x3_core #(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = mi3_pkg::WORD_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic signed [WORD_BITS-1:0] i_m00,
    input  wire logic signed [WORD_BITS-1:0] i_m01,
    input  wire logic signed [WORD_BITS-1:0] i_m02,
    input  wire logic signed [WORD_BITS-1:0] i_m10,
    input  wire logic signed [WORD_BITS-1:0] i_m11,
    input  wire logic signed [WORD_BITS-1:0] i_m12,
    input  wire logic signed [WORD_BITS-1:0] i_m20,
    input  wire logic signed [WORD_BITS-1:0] i_m21,
    input  wire logic signed [WORD_BITS-1:0] i_m22,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic signed [WORD_BITS-1:0]      o_inv00,
    output logic signed [WORD_BITS-1:0]      o_inv01,
    output logic signed [WORD_BITS-1:0]      o_inv02,
    output logic signed [WORD_BITS-1:0]      o_inv10,
    output logic signed [WORD_BITS-1:0]      o_inv11,
    output logic signed [WORD_BITS-1:0]      o_inv12,
    output logic signed [WORD_BITS-1:0]      o_inv20,
    output logic signed [WORD_BITS-1:0]      o_inv21,
    output logic signed [WORD_BITS-1:0]      o_inv22,
    output logic                             o_invertible,
    output logic                             o_saturated
);

    import mi3_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int P   = 2 * W;                 // one element product
    localparam int A   = 2 * W + 1;             // cofactor
    localparam int PP  = 2 * W + 1;             // determinant partial product
    localparam int D   = 3 * W + 3;             // determinant
    localparam int N   = A + 2 * FRAC_BITS;     // scaled numerator magnitude
    localparam int R   = (N > D + W) ? N : D + W;
    localparam int LAT = W + 8;

    // Pipeline advance: hold everything while the output beat is stalled.
    logic en;
    logic [LAT-1:0] r_vld;

    logic signed [W-1:0] w_m [MAT_N];

    // Stage 0: element products.
    logic signed [P-1:0] r_pa [MAT_N];
    logic signed [P-1:0] r_pb [MAT_N];
    logic signed [W-1:0] r_m0_s0 [3];
    // Stage 1: cofactors.
    logic signed [A-1:0] r_adj_s1 [MAT_N];
    logic signed [W-1:0] r_m0_s1 [3];
    // Stage 2: determinant partial products, split on the cofactor.
    logic signed [PP-1:0] r_plo [3];
    logic signed [PP-1:0] r_phi [3];
    logic signed [A-1:0]  r_adj_s2 [MAT_N];
    // Stage 3: determinant terms.
    logic signed [D-1:0] r_term [3];
    logic signed [A-1:0] r_adj_s3 [MAT_N];
    // Stage 4: determinant.
    logic signed [D-1:0] r_det;
    logic signed [A-1:0] r_adj_s4 [MAT_N];
    // Stage 5: magnitudes and signs.
    logic [D-1:0]     r_adet;
    logic             r_dzero;
    logic [N-1:0]     r_num [MAT_N];
    logic [MAT_N-1:0] r_qneg;
    // Stage 6 onward: divider entry, then one quotient bit per stage.
    logic [R-1:0]     r_rem  [W+1][MAT_N];
    logic [W-1:0]     r_q    [W+1][MAT_N];
    logic [MAT_N-1:0] r_ovf  [W+1];
    logic [MAT_N-1:0] r_qn   [W+1];
    logic [D-1:0]     r_ad   [W+1];
    logic             r_dz   [W+1];
    // Output register.
    logic signed [W-1:0] r_inv [MAT_N];
    logic                r_invertible;
    logic                r_sat;

    logic [R-1:0]     w_dsh [W];
    logic [R-1:0]     n_rem [W][MAT_N];
    logic [W-1:0]     n_q   [W][MAT_N];
    logic [MAT_N-1:0] n_ge  [W];

    logic [A-1:0]     w_aadj [MAT_N];
    logic [D-1:0]     w_adet;
    logic signed [W-1:0] n_inv [MAT_N];
    logic [MAT_N-1:0] n_satk;

    assign en         = !r_vld[LAT-1] || !i_out_stall;
    assign o_in_stall = !en;

    assign w_m[0] = i_m00;
    assign w_m[1] = i_m01;
    assign w_m[2] = i_m02;
    assign w_m[3] = i_m10;
    assign w_m[4] = i_m11;
    assign w_m[5] = i_m12;
    assign w_m[6] = i_m20;
    assign w_m[7] = i_m21;
    assign w_m[8] = i_m22;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // Front end: cofactors, then the determinant from row 0.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < MAT_N; k++) begin
                r_pa[k]     <= w_m[ADJ_IDX[k][0]] * w_m[ADJ_IDX[k][1]];
                r_pb[k]     <= w_m[ADJ_IDX[k][2]] * w_m[ADJ_IDX[k][3]];
                r_adj_s1[k] <= A'(r_pa[k]) - A'(r_pb[k]);
                r_adj_s2[k] <= r_adj_s1[k];
                r_adj_s3[k] <= r_adj_s2[k];
                r_adj_s4[k] <= r_adj_s3[k];
            end
            for (int t = 0; t < 3; t++) begin
                r_m0_s0[t] <= w_m[t];
                r_m0_s1[t] <= r_m0_s0[t];
                r_plo[t]   <= r_m0_s1[t] * $signed({1'b0, r_adj_s1[3*t][W-1:0]});
                r_phi[t]   <= r_m0_s1[t] * $signed(r_adj_s1[3*t][A-1:W]);
                r_term[t]  <= (D'(r_phi[t]) <<< W) + D'(r_plo[t]);
            end
            r_det <= r_term[0] + r_term[1] + r_term[2];
        end
    end

    // Magnitudes for the unsigned divide.
    always_comb begin
        w_adet = r_det[D-1] ? D'(-r_det) : D'(r_det);
        for (int k = 0; k < MAT_N; k++) begin
            w_aadj[k] = r_adj_s4[k][A-1] ? A'(-r_adj_s4[k]) : A'(r_adj_s4[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_adet  <= w_adet;
            r_dzero <= (r_det == '0);
            for (int k = 0; k < MAT_N; k++) begin
                r_num[k]  <= N'(w_aadj[k]) << (2 * FRAC_BITS);
                r_qneg[k] <= r_adj_s4[k][A-1] ^ r_det[D-1];
            end
        end
    end

    // One restoring step per stage: quotient bit W-1-j at step j.
    always_comb begin
        for (int j = 0; j < W; j++) begin
            w_dsh[j] = R'(r_ad[j]) << (W - 1 - j);
            for (int k = 0; k < MAT_N; k++) begin
                n_ge[j][k]  = (r_rem[j][k] >= w_dsh[j]);
                n_rem[j][k] = n_ge[j][k] ? (r_rem[j][k] - w_dsh[j]) : r_rem[j][k];
                n_q[j][k]          = r_q[j][k];
                n_q[j][k][W-1-j]   = n_ge[j][k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // Entry: flag any quotient that needs more than W bits.
            r_ad[0] <= r_adet;
            r_dz[0] <= r_dzero;
            r_qn[0] <= r_qneg;
            for (int k = 0; k < MAT_N; k++) begin
                r_rem[0][k] <= R'(r_num[k]);
                r_q[0][k]   <= '0;
                r_ovf[0][k] <= (R'(r_num[k]) >= (R'(r_adet) << W));
            end
            for (int j = 0; j < W; j++) begin
                r_ad[j+1]  <= r_ad[j];
                r_dz[j+1]  <= r_dz[j];
                r_qn[j+1]  <= r_qn[j];
                r_ovf[j+1] <= r_ovf[j];
                for (int k = 0; k < MAT_N; k++) begin
                    r_rem[j+1][k] <= n_rem[j][k];
                    r_q[j+1][k]   <= n_q[j][k];
                end
            end
        end
    end

    // Apply sign and clip. A negative quotient of exactly 2^(W-1) still fits.
    always_comb begin
        for (int k = 0; k < MAT_N; k++) begin
            if (r_qn[W][k]) begin
                n_satk[k] = r_ovf[W][k] ||
                            (r_q[W][k][W-1] && (r_q[W][k][W-2:0] != '0));
                n_inv[k]  = n_satk[k] ? $signed({1'b1, {(W-1){1'b0}}})
                                      : $signed(W'(-r_q[W][k]));
            end else begin
                n_satk[k] = r_ovf[W][k] || r_q[W][k][W-1];
                n_inv[k]  = n_satk[k] ? $signed({1'b0, {(W-1){1'b1}}})
                                      : $signed(r_q[W][k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_invertible <= !r_dz[W];
            r_sat        <= !r_dz[W] && (n_satk != '0);
            for (int k = 0; k < MAT_N; k++) begin
                r_inv[k] <= r_dz[W] ? '0 : n_inv[k];
            end
        end
    end

    assign o_out_valid  = r_vld[LAT-1];
    assign o_inv00      = r_inv[0];
    assign o_inv01      = r_inv[1];
    assign o_inv02      = r_inv[2];
    assign o_inv10      = r_inv[3];
    assign o_inv11      = r_inv[4];
    assign o_inv12      = r_inv[5];
    assign o_inv20      = r_inv[6];
    assign o_inv21      = r_inv[7];
    assign o_inv22      = r_inv[8];
    assign o_invertible = r_invertible;
    assign o_saturated  = r_sat;

    // Checks: singular results are clean, clipping needs an inverse,
    // a beat enters the first stage on advance, and input stalls on output stall.
    `MI3_ASSERT_SAME(a_singular_zero, i_clk, i_rst_n, o_out_valid && !o_invertible, !o_saturated && o_inv00 == '0 && o_inv11 == '0 && o_inv22 == '0)
    `MI3_ASSERT_SAME(a_sat_needs_inv, i_clk, i_rst_n, o_out_valid && o_saturated, o_invertible)
    `MI3_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_vld[0])
    `MI3_ASSERT_SAME(a_hold_on_stall, i_clk, i_rst_n, o_out_valid && i_out_stall, o_in_stall)

endmodule

`default_nettype wire

### tb/matrix_inverse_3x3_core_test.sv
`timescale 1ns / 1ps

module matrix_inverse_3x3_core_test;

    localparam int FRAC = mi3_pkg::FRAC_BITS_DEF;
    localparam int WB   = mi3_pkg::WORD_BITS_DEF;
    localparam int N    = mi3_pkg::MAT_N;
    localparam int LATENCY = WB + 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 1880;

    typedef logic signed [WB-1:0] word_t;
    typedef logic signed [191:0] wide_t;

    typedef struct {
        word_t m [N];
    } matrix_t;

    typedef struct {
        word_t inv [N];
        logic  invertible;
        logic  saturated;
    } inverse_t;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    word_t m_drv [N];
    logic  out_valid;
    logic  out_stall;
    word_t inv_mon [N];
    logic  invertible_mon;
    logic  saturated_mon;

    matrix_t  pending_mats [$];
    inverse_t expected_inverses [$];

    int  mismatches;
    int  results_seen;
    int  singular_seen;
    int  saturated_seen;
    int  idle_cycles;
    bit  in_taken;
    bit  send_gaps;
    bit  recv_gaps;
    bit  hold_sink;
    int  hold_left;
    bit  request_hold;

    matrix_inverse_3x3_core uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_m00        (m_drv[0]),
        .i_m01        (m_drv[1]),
        .i_m02        (m_drv[2]),
        .i_m10        (m_drv[3]),
        .i_m11        (m_drv[4]),
        .i_m12        (m_drv[5]),
        .i_m20        (m_drv[6]),
        .i_m21        (m_drv[7]),
        .i_m22        (m_drv[8]),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_inv00      (inv_mon[0]),
        .o_inv01      (inv_mon[1]),
        .o_inv02      (inv_mon[2]),
        .o_inv10      (inv_mon[3]),
        .o_inv11      (inv_mon[4]),
        .o_inv12      (inv_mon[5]),
        .o_inv20      (inv_mon[6]),
        .o_inv21      (inv_mon[7]),
        .o_inv22      (inv_mon[8]),
        .o_invertible (invertible_mon),
        .o_saturated  (saturated_mon)
    );

    always begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Adjugate over determinant, exact: 2x2 minors fit 65 bits, the
    // determinant 99 bits and the shifted numerator 97 bits, so 192 is plenty.
    function automatic inverse_t invert_matrix(matrix_t a);
        inverse_t res;
        wide_t    w [N];
        wide_t    adj [N];
        wide_t    det;
        wide_t    num;
        wide_t    quo;
        wide_t    max_w;
        wide_t    min_w;
        for (int k = 0; k < N; k++) begin
            w[k] = a.m[k];
        end
        for (int k = 0; k < N; k++) begin
            adj[k] = w[mi3_pkg::ADJ_IDX[k][0]] * w[mi3_pkg::ADJ_IDX[k][1]]
                   - w[mi3_pkg::ADJ_IDX[k][2]] * w[mi3_pkg::ADJ_IDX[k][3]];
        end
        det = w[0] * adj[0] + w[1] * adj[3] + w[2] * adj[6];
        res.saturated = 1'b0;
        res.invertible = (det != 0);
        max_w = (wide_t'(1) <<< (WB - 1)) - 1;
        min_w = -(wide_t'(1) <<< (WB - 1));
        for (int k = 0; k < N; k++) begin
            res.inv[k] = '0;
            if (det != 0) begin
                num = adj[k] <<< (2 * FRAC);
                // signed / truncates toward zero
                quo = num / det;
                if (quo > max_w) begin
                    res.inv[k] = max_w[WB-1:0];
                    res.saturated = 1'b1;
                end else if (quo < min_w) begin
                    res.inv[k] = min_w[WB-1:0];
                    res.saturated = 1'b1;
                end else begin
                    res.inv[k] = quo[WB-1:0];
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [WB-1:0] got, logic [WB-1:0] want);
        $display("mismatch on %s at result %0d: got %h, expected %h",
                 field, results_seen, got, want);
        mismatches++;
    endtask

    function automatic word_t random_word();
        word_t v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            1: v = word_t'($urandom_range(0, 4)) <<< FRAC;
            2: v = -(word_t'($urandom_range(0, 4)) <<< FRAC);
            3: v = word_t'($signed($urandom_range(0, 511)) - 256);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic matrix_t random_matrix();
        matrix_t a;
        int      kind;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < N; k++) begin
            a.m[k] = random_word();
        end
        if (kind == 0) begin
            // duplicate a row: singular
            for (int c = 0; c < 3; c++) begin
                a.m[6 + c] = a.m[c];
            end
        end else if (kind == 1) begin
            // diagonal with small entries: large inverse, clipped only for entries of 1 or 2
            for (int k = 0; k < N; k++) begin
                a.m[k] = (k % 4 == 0) ? word_t'($urandom_range(1, 40000)) : '0;
            end
        end else if (kind <= 4) begin
            // near twice the identity, well conditioned
            for (int k = 0; k < N; k++) begin
                a.m[k] = word_t'($signed($urandom_range(0, 32767)) - 16384);
                if (k % 4 == 0) begin
                    a.m[k] = a.m[k] + (32'sd1 <<< (FRAC + 1));
                end
            end
        end
        return a;
    endfunction

    function automatic matrix_t diag_matrix(word_t d0, word_t d1, word_t d2);
        matrix_t a;
        for (int k = 0; k < N; k++) begin
            a.m[k] = '0;
        end
        a.m[0] = d0;
        a.m[4] = d1;
        a.m[8] = d2;
        return a;
    endfunction

    // Driver: present the head of the pending queue; the head advances at the
    // rising edge that accepts it.
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_taken) begin
                // hold the stalled beat
            end else if (pending_mats.size() > 0 && !(send_gaps && $urandom_range(0, 99) < 33)) begin
                in_valid <= 1'b1;
                for (int k = 0; k < N; k++) begin
                    m_drv[k] <= pending_mats[0].m[k];
                end
            end else begin
                in_valid <= 1'b0;
                for (int k = 0; k < N; k++) begin
                    m_drv[k] <= $urandom;
                end
            end
        end
    end

    // Receiver stall, with one long hold counted here.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (request_hold && !hold_sink) begin
            hold_sink <= 1'b1;
            out_stall <= 1'b1;
            hold_left <= 300;
        end else begin
            out_stall <= recv_gaps && ($urandom_range(0, 99) < 33);
        end
    end

    // Predict on input acceptance, check on output acceptance.
    always @(posedge clk) begin
        in_taken = rst_n && in_valid && !in_stall;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                matrix_t a;
                for (int k = 0; k < N; k++) begin
                    a.m[k] = m_drv[k];
                end
                expected_inverses.push_back(invert_matrix(a));
                void'(pending_mats.pop_front());
            end
            if (out_valid && !out_stall) begin
                if (expected_inverses.size() == 0) begin
                    report_mismatch("unexpected beat", '0, '0);
                end else begin
                    inverse_t want;
                    want = expected_inverses.pop_front();
                    for (int k = 0; k < N; k++) begin
                        if (inv_mon[k] !== want.inv[k]) begin
                            report_mismatch($sformatf("inv%0d%0d", k / 3, k % 3),
                                            inv_mon[k], want.inv[k]);
                        end
                    end
                    if (invertible_mon !== want.invertible) begin
                        report_mismatch("invertible", invertible_mon, want.invertible);
                    end
                    if (saturated_mon !== want.saturated) begin
                        report_mismatch("saturated", saturated_mon, want.saturated);
                    end
                    if (!want.invertible) begin
                        singular_seen++;
                    end
                    if (want.saturated) begin
                        saturated_seen++;
                    end
                end
                results_seen++;
            end
        end
    end

    // Watchdog: count cycles with no beat accepted on either side.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results outstanding",
                         expected_inverses.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        matrix_t a;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        for (int k = 0; k < N; k++) begin
            m_drv[k] = '0;
        end
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        hold_sink = 1'b0;
        request_hold = 1'b0;
        mismatches = 0;
        results_seen = 0;
        singular_seen = 0;
        saturated_seen = 0;
        idle_cycles = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: identity, zero, scaled, extremes, singular, clipping, then five random.
        pending_mats.push_back(diag_matrix(32'sh10000, 32'sh10000, 32'sh10000));
        pending_mats.push_back(diag_matrix(0, 0, 0));
        pending_mats.push_back(diag_matrix(32'sh20000, -32'sh40000, 32'sh8000));
        pending_mats.push_back(diag_matrix(1, 1, 1));
        pending_mats.push_back(diag_matrix(-1, 1, -1));
        pending_mats.push_back(diag_matrix(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
        pending_mats.push_back(diag_matrix(32'sh80000000, 32'sh80000000, 32'sh80000000));
        pending_mats.push_back(diag_matrix(32'sh80000000, 32'sh7fffffff, -1));
        for (int k = 0; k < N; k++) begin
            a.m[k] = 32'sh7fffffff;
        end
        pending_mats.push_back(a);
        for (int k = 0; k < N; k++) begin
            a.m[k] = 32'sh80000000;
        end
        pending_mats.push_back(a);
        for (int k = 0; k < N; k++) begin
            a.m[k] = (k % 2) ? 32'sh80000000 : 32'sh7fffffff;
        end
        pending_mats.push_back(a);
        for (int k = 0; k < N; k++) begin
            a.m[k] = word_t'(k + 1) <<< FRAC;
        end
        pending_mats.push_back(a);
        a.m[8] = 32'sh000a0000;
        pending_mats.push_back(a);
        for (int k = 0; k < N; k++) begin
            a.m[k] = (k == 2 || k == 4 || k == 6) ? 32'sh10000 : '0;
        end
        pending_mats.push_back(a);
        for (int k = 0; k < N; k++) begin
            a.m[k] = (k == 2 || k == 4 || k == 6) ? -32'sh3 : '0;
        end
        pending_mats.push_back(a);
        for (int i = 0; i < 5; i++) begin
            pending_mats.push_back(random_matrix());
        end
        wait (pending_mats.size() == 0);

        // Random with no gaps, then with gaps, a long sink hold, a drain pause.
        for (int i = 0; i < 300; i++) begin
            pending_mats.push_back(random_matrix());
        end
        wait (pending_mats.size() == 0);
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        request_hold = 1'b1;
        for (int i = 0; i < 600; i++) begin
            pending_mats.push_back(random_matrix());
        end
        wait (pending_mats.size() == 0);
        wait (expected_inverses.size() == 0);
        for (int i = 0; i < N_RANDOM - 900; i++) begin
            pending_mats.push_back(random_matrix());
        end
        wait (pending_mats.size() == 0);
        wait (expected_inverses.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);

        $display("%0d matrices checked: %0d singular, %0d clipped, with random stalls",
                 results_seen, singular_seen, saturated_seen);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/mi3_pkg.sv
hdl/matrix_inverse_3x3_core.sv
tb/matrix_inverse_3x3_core_test.sv
